// ===== design/bffc_pkg.sv =====
package bffc_pkg;

    // default board geometry limits
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] CFG_RST = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    // fill engine sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_EMIT
    } t_state;

    // engine status toward the top level
    typedef struct packed {
        logic busy;     // fill or emit in progress
        logic filling;  // sweep passes running
    } t_eng_stat;

endpackage

// ===== design/bffc_lane.sv =====
// One column lane: masking, border seed and one growth step for its cell.
module bffc_lane #(
    parameter int COL    = 0,
    parameter int CCNT_W = 7
) (
    input  logic [CCNT_W-1:0] i_cols,
    input  logic              i_seed,
    input  logic              i_row_edge,
    input  logic              i_arr_cell,
    input  logic              i_arr_reach,
    input  logic              i_cur,
    input  logic              i_open,
    input  logic              i_up,
    input  logic              i_down,
    input  logic              i_left,
    input  logic              i_right,
    output logic              o_in_use,
    output logic              o_arr_open,
    output logic              o_arr_reach,
    output logic              o_nxt
);

    logic col_edge;

    assign o_in_use    = CCNT_W'(COL) < i_cols;
    assign col_edge    = (COL == 0) || (CCNT_W'(COL + 1) == i_cols);
    assign o_arr_open  = i_arr_cell & o_in_use;
    // first pass starts from open border cells instead of stored state
    assign o_arr_reach = i_seed ? (o_arr_open & (i_row_edge | col_edge)) : i_arr_reach;
    assign o_nxt       = i_cur | (i_open & (i_up | i_down | i_left | i_right));

endmodule

// ===== design/bffc_engine.sv =====
// Row stores, sweep sequencer, column lanes and change merge.
module bffc_engine #(
    parameter int MAX_ROWS = bffc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = bffc_pkg::MAX_COLS_DEF,
    localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CNT_W   = $clog2(MAX_ROWS + 1),
    localparam int CCNT_W  = $clog2(MAX_COLS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CNT_W-1:0]      i_rows,
    input  logic [CCNT_W-1:0]     i_cols,
    input  logic                  i_load,
    input  logic [RIDX_W-1:0]     i_load_idx,
    input  logic [MAX_COLS-1:0]   i_load_row,
    input  logic                  i_start,
    input  logic                  i_out_stall,
    output bffc_pkg::t_eng_stat   o_stat,
    output logic                  o_out_valid,
    output logic [MAX_COLS-1:0]   o_result,
    output logic                  o_last
);

    localparam int K_W = $clog2(MAX_ROWS + 2);

    // row stores
    logic [MAX_COLS-1:0] r_cell_mem  [MAX_ROWS];
    logic [MAX_COLS-1:0] r_reach_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_cell_q;
    logic [MAX_COLS-1:0] r_reach_q;

    bffc_pkg::t_state r_state;
    bffc_pkg::t_state n_state;

    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   wr_k;
    logic [K_W-1:0]   k_n;
    logic             r_pass0;
    logic             r_changed;
    logic [CNT_W-1:0] r_erow;
    logic             r_ovalid;
    logic             r_olast;

    logic [MAX_COLS-1:0] r_cur_reach;
    logic [MAX_COLS-1:0] r_cur_open;
    logic [MAX_COLS-1:0] r_up;

    logic [MAX_COLS-1:0] in_use;
    logic [MAX_COLS-1:0] arr_open;
    logic [MAX_COLS-1:0] arr_reach;
    logic [MAX_COLS-1:0] down_vec;
    logic [MAX_COLS-1:0] nxt_vec;
    logic [MAX_COLS+1:0] cur_pad;

    logic              is_fill;
    logic              arr_valid;
    logic              row_edge;
    logic              proc;
    logic              pass_end;
    logic              lane_chg;
    logic              any_chg;
    logic              emit_last;
    logic              rd_en;
    logic [RIDX_W-1:0] rd_addr;

    // sweep window timing: at step k row k is read, row k-1 arrives,
    // row k-2 is updated and written back
    assign k_n       = K_W'(i_rows);
    assign wr_k      = r_k - K_W'(2);
    assign is_fill   = (r_state == bffc_pkg::ST_FILL);
    assign arr_valid = (r_k != '0) && (r_k <= k_n);
    assign row_edge  = (r_k == K_W'(1)) || (r_k == k_n);
    assign proc      = r_k >= K_W'(2);
    assign pass_end  = r_k == (k_n + K_W'(1));
    assign down_vec  = (r_k <= k_n) ? arr_reach : '0;
    assign cur_pad   = {1'b0, r_cur_reach, 1'b0};
    assign lane_chg  = |(nxt_vec ^ r_cur_reach);
    assign any_chg   = r_changed | (proc & lane_chg);
    assign emit_last = (r_erow + CNT_W'(1)) == i_rows;

    for (genvar j = 0; j < MAX_COLS; j++) begin : g_lane
        bffc_lane #(
            .COL    (j),
            .CCNT_W (CCNT_W)
        ) u_lane (
            .i_cols      (i_cols),
            .i_seed      (r_pass0),
            .i_row_edge  (row_edge),
            .i_arr_cell  (r_cell_q[j]),
            .i_arr_reach (r_reach_q[j]),
            .i_cur       (r_cur_reach[j]),
            .i_open      (r_cur_open[j]),
            .i_up        (r_up[j]),
            .i_down      (down_vec[j]),
            .i_left      (cur_pad[j]),
            .i_right     (cur_pad[j+2]),
            .o_in_use    (in_use[j]),
            .o_arr_open  (arr_open[j]),
            .o_arr_reach (arr_reach[j]),
            .o_nxt       (nxt_vec[j])
        );
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_k[RIDX_W-1:0];
        case (r_state)
            bffc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = bffc_pkg::ST_FILL;
                end
            end
            bffc_pkg::ST_FILL: begin
                rd_en = r_k < k_n;
                if (pass_end && !any_chg) begin
                    n_state = bffc_pkg::ST_EMIT;
                end
            end
            bffc_pkg::ST_EMIT: begin
                rd_en   = !r_ovalid || !i_out_stall;
                rd_addr = r_erow[RIDX_W-1:0];
                if (rd_en && emit_last) begin
                    n_state = bffc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bffc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bffc_pkg::ST_IDLE;
            r_k       <= '0;
            r_pass0   <= 1'b0;
            r_changed <= 1'b0;
            r_erow    <= '0;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bffc_pkg::ST_IDLE && i_start) begin
                r_k       <= '0;
                r_pass0   <= 1'b1;
                r_changed <= 1'b0;
            end
            if (is_fill) begin
                if (pass_end) begin
                    r_k       <= '0;
                    r_pass0   <= 1'b0;
                    r_changed <= 1'b0;
                    r_erow    <= '0;
                end else begin
                    r_k <= r_k + K_W'(1);
                    if (proc && lane_chg) begin
                        r_changed <= 1'b1;
                    end
                end
            end
            if (r_state == bffc_pkg::ST_EMIT && rd_en) begin
                r_erow   <= r_erow + CNT_W'(1);
                r_ovalid <= 1'b1;
                r_olast  <= emit_last;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cell_mem[i_load_idx] <= i_load_row & in_use;
        end
        if (rd_en) begin
            r_cell_q  <= r_cell_mem[rd_addr];
            r_reach_q <= r_reach_mem[rd_addr];
        end
        if (is_fill && proc) begin
            r_reach_mem[wr_k[RIDX_W-1:0]] <= nxt_vec;
        end
        if (is_fill) begin
            if (r_k == '0) begin
                r_up <= '0;
            end else if (proc) begin
                r_up <= nxt_vec;
            end
            if (arr_valid) begin
                r_cur_reach <= arr_reach;
                r_cur_open  <= arr_open;
            end
        end
    end

    assign o_stat.busy    = (r_state != bffc_pkg::ST_IDLE);
    assign o_stat.filling = is_fill;
    assign o_out_valid    = r_ovalid;
    assign o_result       = r_cell_q & r_reach_q & in_use;
    assign o_last         = r_olast;

endmodule

// ===== design/border_flood_fill_capture.sv =====
// Border-connected flood fill on a binary board.
//
// Input channel (i_in_valid / o_in_stall): one board row per beat, bit j set
// means column j is open. Columns at or beyond board_cols are dropped.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
// board_rows, index 1 sets board_cols; 0 acts as 1, larger values clamp to
// MAX_ROWS / MAX_COLS. Write only while the block is idle.
// Output channel (o_out_valid / i_out_stall): after the beat that completes
// a board, one beat per board row, o_last_row set on the final one. Only open
// cells 4-connected to an open border cell come out set.
// Timing: rows load at one per cycle. The fill sweeps the row store top to
// bottom, one row per cycle, and repeats until a pass changes nothing. Rows
// then leave at one per cycle while the output is not stalled; the first row
// is read once the emit state is entered and comes out registered. Input
// stalls during fill and emit, and also when a completing row would meet a
// still-pending last output row.
// The stall on the output simply holds the current beat; the row store read
// port holds its data until taken.
// Reset (synchronous, active low): registers to 64/64, no rows loaded.
module border_flood_fill_capture #(
    parameter int MAX_ROWS = bffc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = bffc_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // row input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [MAX_COLS-1:0]           i_row_cells,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [MAX_COLS-1:0]           o_result_cells,
    output logic                          o_last_row,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bffc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bffc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW     = bffc_pkg::CFG_W;
    localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CNT1_W = CNT_W + 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);

    logic [CW-1:0]      r_rows_cfg;
    logic [CW-1:0]      r_cols_cfg;
    logic [CW-1:0]      rows_sat;
    logic [CW-1:0]      cols_sat;
    logic [CNT_W-1:0]   rows_eff;
    logic [CCNT_W-1:0]  cols_eff;
    logic [CNT_W-1:0]   r_loaded;
    logic [CNT1_W-1:0]  loaded_inc;
    logic               completes;
    logic               in_beat;
    bffc_pkg::t_eng_stat eng_stat;

    // clamp register values to the usable range
    assign rows_sat = (r_rows_cfg == '0) ? CW'(1) :
                      (r_rows_cfg > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : r_rows_cfg;
    assign cols_sat = (r_cols_cfg == '0) ? CW'(1) :
                      (r_cols_cfg > CW'(MAX_COLS)) ? CW'(MAX_COLS) : r_cols_cfg;
    assign rows_eff = CNT_W'(rows_sat);
    assign cols_eff = CCNT_W'(cols_sat);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= bffc_pkg::CFG_RST;
            r_cols_cfg <= bffc_pkg::CFG_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bffc_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data;
                bffc_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // board fill count; a board completes once the count reaches the row
    // setting in force at that beat
    assign loaded_inc = {1'b0, r_loaded} + CNT1_W'(1);
    assign completes  = loaded_inc >= {1'b0, rows_eff};
    assign o_in_stall = eng_stat.busy || (o_out_valid && completes);
    assign in_beat    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
        end else if (in_beat) begin
            r_loaded <= completes ? '0 : loaded_inc[CNT_W-1:0];
        end
    end

    bffc_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows      (rows_eff),
        .i_cols      (cols_eff),
        .i_load      (in_beat),
        .i_load_idx  (r_loaded[RIDX_W-1:0]),
        .i_load_row  (i_row_cells),
        .i_start     (in_beat && completes),
        .i_out_stall (i_out_stall),
        .o_stat      (eng_stat),
        .o_out_valid (o_out_valid),
        .o_result    (o_result_cells),
        .o_last      (o_last_row)
    );

    // a completing beat must hand the board to the fill engine
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && completes) |=> eng_stat.busy)
        else $error("completed board did not start the fill");

    // no result beats while the sweep passes are running
    a_fill_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.filling |-> !o_out_valid)
        else $error("output valid during fill");

    // nothing follows the last row of a board until the next board
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_row) |=> !o_out_valid)
        else $error("beat after last row");

    // row count never reaches the store depth between boards
    a_loaded_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded < CNT_W'(MAX_ROWS))
        else $error("row count out of range");

endmodule

// ===== verif/border_flood_fill_capture_tb.sv =====
`timescale 1ns / 100ps

module border_flood_fill_capture_tb;

    localparam int COLS        = bffc_pkg::MAX_COLS_DEF;
    localparam int ROWS        = bffc_pkg::MAX_ROWS_DEF;
    localparam int CW          = bffc_pkg::CFG_W;
    localparam int RAND_ITEMS  = 126;
    localparam int DRAIN_CYC   = 8;      // settle time before a register write
    localparam int TAIL_CYC    = 50;     // quiet time after the last result
    localparam int HOLD_CYC    = 400;    // long receiver hold-off
    localparam int LIMIT_NS    = 2_000_000;

    typedef struct packed {
        logic [COLS-1:0] cells;
        logic            last;
    } t_result_row;

    typedef enum logic {DO_CFG, DO_ROW} t_act;

    // one line of the directed script
    typedef struct packed {
        t_act               act;
        bffc_pkg::t_cfg_idx idx;
        logic [CW-1:0]      val;
        logic [COLS-1:0]    cells;
        logic               typed;   // expected row typed in below, 1-row boards only
        logic [COLS-1:0]    want;
    } t_script_line;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic [COLS-1:0]                 i_row_cells = '0;
    logic                            i_out_stall = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [bffc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CW-1:0]                   i_cfg_data  = '0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [COLS-1:0]                 o_result_cells;
    logic                            o_last_row;
    logic                            o_cfg_ready;

    border_flood_fill_capture u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_row_cells    (i_row_cells),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_cells (o_result_cells),
        .o_last_row     (o_last_row),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Board predictor: own copy of registers, row store and load count.
    // ------------------------------------------------------------------
    logic [CW-1:0]    rows_cfg = bffc_pkg::CFG_RST;
    logic [CW-1:0]    cols_cfg = bffc_pkg::CFG_RST;
    logic [COLS-1:0]  row_store [0:ROWS-1];
    int unsigned      rows_in  = 0;
    t_result_row      results_due [$];

    int  mismatches = 0;
    bit  calm       = 0;    // no idling on either side
    bit  hold_req   = 0;    // ask the receiver for one long hold-off
    bit  hold_done  = 0;

    // 0 acts as 1, anything past 64 clamps
    function automatic int unsigned clamp_dim(logic [CW-1:0] v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return 32'(v);
    endfunction

    function automatic logic [COLS-1:0] span_mask(int unsigned m);
        return (m >= 64) ? '1 : ((64'd1 << m) - 64'd1);
    endfunction

    // Border seed, then grow through open neighbors until a sweep changes
    // nothing. Pushes one expected beat per board row.
    task automatic flood_board(int unsigned n, int unsigned m, logic [COLS-1:0] msk);
        logic [COLS-1:0] hit [0:ROWS-1];
        logic [COLS-1:0] edges, open_r, nb, nxt;
        bit              grew;
        int              r;
        edges = 64'd1 | (64'd1 << (m - 1));
        for (r = 0; r < n; r++) begin
            open_r = row_store[r] & msk;
            hit[r] = (r == 0 || r == n - 1) ? open_r : (open_r & edges);
        end
        grew = 1;
        while (grew) begin
            grew = 0;
            for (r = 0; r < n; r++) begin
                open_r = row_store[r] & msk;
                nb     = (hit[r] << 1) | (hit[r] >> 1);
                if (r > 0)     nb |= hit[r-1];
                if (r + 1 < n) nb |= hit[r+1];
                nxt = hit[r] | (nb & open_r);
                if (nxt != hit[r]) begin
                    hit[r] = nxt;
                    grew   = 1;
                end
            end
        end
        for (r = 0; r < n; r++)
            results_due.push_back({row_store[r] & hit[r] & msk, (r == n - 1)});
    endtask

    // A row beat was taken; board geometry is whatever is in force now.
    task automatic take_row(logic [COLS-1:0] cells, logic typed, logic [COLS-1:0] want);
        int unsigned     n;
        int unsigned     m;
        logic [COLS-1:0] msk;
        n   = clamp_dim(rows_cfg);
        m   = clamp_dim(cols_cfg);
        msk = span_mask(m);
        if (rows_in >= ROWS) rows_in = 0;
        row_store[rows_in] = cells & msk;
        rows_in++;
        if (rows_in >= n) begin
            rows_in = 0;
            if (typed) results_due.push_back({want, 1'b1});
            else flood_board(n, m, msk);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Called at an edge; returns at the edge that took the beat.
    task automatic send_row(logic [COLS-1:0] cells, logic typed, logic [COLS-1:0] want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_row_cells <= cells;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        take_row(cells, typed, want);
    endtask

    // Only while idle: nothing pending, plus a settle wait for the last load.
    task automatic write_reg(bffc_pkg::t_cfg_idx idx, logic [CW-1:0] val);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == bffc_pkg::CFG_ROWS) rows_cfg = val;
        else cols_cfg = val;
    endtask

    function automatic t_script_line reg_line(bffc_pkg::t_cfg_idx idx, logic [CW-1:0] val);
        return {DO_CFG, idx, val, {COLS{1'b0}}, 1'b0, {COLS{1'b0}}};
    endfunction

    function automatic t_script_line row_line(logic [COLS-1:0] cells);
        return {DO_ROW, bffc_pkg::CFG_ROWS, {CW{1'b0}}, cells, 1'b0, {COLS{1'b0}}};
    endfunction

    function automatic t_script_line row_checked(logic [COLS-1:0] cells,
                                                 logic [COLS-1:0] want);
        return {DO_ROW, bffc_pkg::CFG_ROWS, {CW{1'b0}}, cells, 1'b1, want};
    endfunction

    function automatic logic [CW-1:0] pick_rows();
        case ($urandom_range(0, 9))
            0:       return CW'(0);
            1:       return CW'(1);
            default: return CW'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_cols();
        case ($urandom_range(0, 9))
            0:       return CW'(0);
            1:       return CW'(64);
            2:       return CW'($urandom_range(65, 127));
            3:       return CW'($urandom_range(17, 63));
            default: return CW'($urandom_range(1, 16));
        endcase
    endfunction

    // density: sparse, half, dense
    function automatic logic [COLS-1:0] shape_row(int mode);
        logic [COLS-1:0] w;
        w = {$urandom, $urandom};
        if (mode == 0) w &= {$urandom, $urandom};
        else if (mode == 2) w |= {$urandom, $urandom};
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_script_line script [$];
        int           rand_rows;
        int           mode;
        bit           broken;

        // 1x1 boards, then the out-of-range register values
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd1));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd1));
        script.push_back(row_checked(64'h0000_0000_0000_0001, 64'h1));
        script.push_back(row_checked(64'hFFFF_FFFF_FFFF_FFFE, 64'h0));
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd0));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd0));
        script.push_back(row_checked('1, 64'h1));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd127));
        // single full-width row: every open cell is on the border
        script.push_back(row_checked('1, '1));
        script.push_back(row_checked('0, '0));
        script.push_back(row_checked(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA));
        script.push_back(row_checked(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555));
        // 5x5 ring with an enclosed center cell; junk above the columns
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd5));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd5));
        script.push_back(row_line(64'hF000_0000_0000_001F));
        script.push_back(row_line(64'h0F00_0000_0000_0011));
        script.push_back(row_line(64'h00F0_0000_0000_0015));
        script.push_back(row_line(64'h000F_0000_0000_0011));
        script.push_back(row_line(64'h8000_0000_0000_001F));
        // row count lowered mid-board: next beat completes it
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd4));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd8));
        script.push_back(row_line(64'hFF00_0000_0000_0081));
        script.push_back(row_line(64'h0000_0000_0000_003C));
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd2));
        script.push_back(row_line(64'h0000_0000_0000_00FF));
        // column count narrowed mid-board
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd3));
        script.push_back(row_line(64'h0000_0000_0000_00FF));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd3));
        script.push_back(row_line(64'h0000_0000_0000_0002));
        script.push_back(row_line(64'h0000_0000_0000_0007));
        // 6x6 winding path from the top edge
        script.push_back(reg_line(bffc_pkg::CFG_ROWS, 7'd6));
        script.push_back(reg_line(bffc_pkg::CFG_COLS, 7'd6));
        script.push_back(row_line(64'h02));
        script.push_back(row_line(64'h1E));
        script.push_back(row_line(64'h10));
        script.push_back(row_line(64'h1E));
        script.push_back(row_line(64'h0A));
        script.push_back(row_line(64'h00));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].act == DO_CFG) write_reg(script[i].idx, script[i].val);
            else send_row(script[i].cells, script[i].typed, script[i].want);
        end

        // random boards; mostly whole boards, some cut by a register write
        rand_rows = 0;
        while (rand_rows < RAND_ITEMS) begin
            calm = (rand_rows >= RAND_ITEMS * 4 / 5);
            if (!hold_req && rand_rows >= 30) begin
                // one full 64x64 board, then lean on the output while the
                // next board's rows queue up at the input
                write_reg(bffc_pkg::CFG_ROWS, CW'($urandom_range(64, 127)));
                write_reg(bffc_pkg::CFG_COLS, 7'd64);
                repeat (64) begin
                    send_row(shape_row(2), 1'b0, '0);
                    rand_rows++;
                end
                hold_req = 1;
                repeat (3) begin
                    send_row(shape_row(1), 1'b0, '0);
                    rand_rows++;
                end
                write_reg(bffc_pkg::CFG_ROWS, pick_rows());
            end else begin
                if ($urandom_range(0, 1)) write_reg(bffc_pkg::CFG_ROWS, pick_rows());
                if ($urandom_range(0, 1)) write_reg(bffc_pkg::CFG_COLS, pick_cols());
            end
            mode   = $urandom_range(0, 2);
            broken = ($urandom_range(0, 7) == 0);
            do begin
                send_row(shape_row(mode), 1'b0, '0);
                rand_rows++;
                if (broken && rows_in != 0) begin
                    broken = 0;
                    if ($urandom_range(0, 1)) write_reg(bffc_pkg::CFG_ROWS, pick_rows());
                    else write_reg(bffc_pkg::CFG_COLS, pick_cols());
                end
            end while (rows_in != 0);
        end

        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output pacing: short random stall bursts, quiet stretches, and one
    // long hold-off once the big board starts coming out.
    // ------------------------------------------------------------------
    initial begin : out_pacing
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done && o_out_valid) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_done = 1;
                i_out_stall <= 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        i_out_stall <= 1'b1;
                        repeat ($urandom_range(1, 5)) @(posedge i_clk);
                        i_out_stall <= 1'b0;
                    end
                    2: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(10, 40)) @(posedge i_clk);
                    end
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: each beat against the oldest expected row.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result_row head;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: cells=%h last=%b",
                             o_result_cells, o_last_row);
            end else begin
                head = results_due.pop_front();
                if (o_result_cells !== head.cells || o_last_row !== head.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want cells=%h last=%b, got cells=%h last=%b",
                                 head.cells, head.last, o_result_cells, o_last_row);
                end
            end
        end
    end

    initial begin : watchdog
        #LIMIT_NS;
        $display("tb: failure");
        $finish;
    end

endmodule
